// ===== rtl/ppcc_pkg.sv =====
package ppcc_pkg;

    // Field widths
    localparam int COORD_W   = 24;   // signed Q12.12 coordinate
    localparam int BOX_W     = 23;   // unsigned Q11.12 box length
    localparam int CUT_W     = 48;   // unsigned Q24.24 squared cutoff
    localparam int CLASS_W   = 3;    // shell number, 0 means outside
    localparam int CFG_IDX_W = 3;    // configuration register index

    // Datapath widths
    localparam int MAG_W  = COORD_W + 1;   // |ref - cand| stays below 2^24
    localparam int SQ_W   = 2 * MAG_W - 1; // square stays below 2^48
    localparam int DIST_W = SQ_W + 1;      // sum of three squares below 2^50

    // Cutoff register file
    localparam int CUT_REGS           = 4;
    localparam int MAX_SHELLS_DEFAULT = 4;

    localparam logic [BOX_W-1:0] BOX_RESET = {BOX_W{1'b1}};

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_X      = 3'd0,
        REG_BOX_Y      = 3'd1,
        REG_BOX_Z      = 3'd2,
        REG_CUT_FIRST  = 3'd3,
        REG_CUT_SECOND = 3'd4,
        REG_CUT_THIRD  = 3'd5,
        REG_CUT_FOURTH = 3'd6,
        REG_ACTIVE     = 3'd7
    } cfg_reg_t;

    // Per-stage load enables of the pipeline
    typedef struct packed {
        logic diff;
        logic fold;
        logic square;
        logic sum;
        logic result;
    } pipe_en_t;

endpackage

// ===== rtl/ppcc_cfg.sv =====
module ppcc_cfg #(
    parameter int NUM_CUT = ppcc_pkg::CUT_REGS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [ppcc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppcc_pkg::CUT_W-1:0]        cfg_wdata,
    output logic [ppcc_pkg::BOX_W-1:0]        box_width_x,
    output logic [ppcc_pkg::BOX_W-1:0]        box_width_y,
    output logic [ppcc_pkg::BOX_W-1:0]        box_width_z,
    output logic [NUM_CUT-1:0][ppcc_pkg::CUT_W-1:0] cutoff_sq,
    output logic [ppcc_pkg::CLASS_W-1:0]      active_count
);
    import ppcc_pkg::*;

    localparam logic [CLASS_W-1:0] ACTIVE_RESET =
        (MAX_SHELLS_DEFAULT < NUM_CUT) ? CLASS_W'(MAX_SHELLS_DEFAULT) : CLASS_W'(NUM_CUT);

    logic [BOX_W-1:0]              box_x_reg, box_x_next;
    logic [BOX_W-1:0]              box_y_reg, box_y_next;
    logic [BOX_W-1:0]              box_z_reg, box_z_next;
    logic [NUM_CUT-1:0][CUT_W-1:0] cut_reg, cut_next;
    logic [CLASS_W-1:0]            active_reg, active_next;
    logic [CLASS_W-1:0]            active_wr;

    // Saturate the shell count to the cutoffs that exist
    assign active_wr = (int'(cfg_wdata[CLASS_W-1:0]) > NUM_CUT) ?
                       CLASS_W'(NUM_CUT) : cfg_wdata[CLASS_W-1:0];

    // Decode the write
    always_comb begin
        box_x_next  = box_x_reg;
        box_y_next  = box_y_reg;
        box_z_next  = box_z_reg;
        cut_next    = cut_reg;
        active_next = active_reg;
        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BOX_X:  box_x_next  = cfg_wdata[BOX_W-1:0];
                REG_BOX_Y:  box_y_next  = cfg_wdata[BOX_W-1:0];
                REG_BOX_Z:  box_z_next  = cfg_wdata[BOX_W-1:0];
                REG_ACTIVE: active_next = active_wr;
                REG_CUT_FIRST, REG_CUT_SECOND, REG_CUT_THIRD, REG_CUT_FOURTH: begin
                    // cutoffs decoded below; those beyond NUM_CUT are dropped
                end
            endcase
            for (int i = 0; i < NUM_CUT; i++) begin
                if (cfg_index == CFG_IDX_W'(int'(REG_CUT_FIRST) + i)) begin
                    cut_next[i] = cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_x_reg  <= BOX_RESET;
            box_y_reg  <= BOX_RESET;
            box_z_reg  <= BOX_RESET;
            cut_reg    <= '0;
            active_reg <= ACTIVE_RESET;
        end else begin
            box_x_reg  <= box_x_next;
            box_y_reg  <= box_y_next;
            box_z_reg  <= box_z_next;
            cut_reg    <= cut_next;
            active_reg <= active_next;
        end
    end

    assign box_width_x  = box_x_reg;
    assign box_width_y  = box_y_reg;
    assign box_width_z  = box_z_reg;
    assign cutoff_sq    = cut_reg;
    assign active_count = active_reg;

endmodule

// ===== rtl/ppcc_axis.sv =====
module ppcc_axis (
    input  logic                              aclk,
    input  ppcc_pkg::pipe_en_t                en,
    input  logic signed [ppcc_pkg::COORD_W-1:0] ref_pos,
    input  logic signed [ppcc_pkg::COORD_W-1:0] cand_pos,
    input  logic [ppcc_pkg::BOX_W-1:0]        box_width,
    output logic [ppcc_pkg::SQ_W-1:0]         axis_sq
);
    import ppcc_pkg::*;

    logic signed [MAG_W-1:0] diff;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic                    wrap;
    logic signed [MAG_W:0]   folded;
    logic [MAG_W-1:0]        fold_reg, fold_next;
    logic [2*MAG_W-1:0]      product;
    logic [SQ_W-1:0]         sq_reg;

    // Stage 1: absolute difference
    assign diff     = MAG_W'(ref_pos) - MAG_W'(cand_pos);
    assign mag_next = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

    // Stage 2: fold once by the box width when past half the box
    assign wrap      = {mag_reg, 1'b0} > (MAG_W + 1)'(box_width);
    assign folded    = wrap ? ((MAG_W + 1)'(mag_reg) - (MAG_W + 1)'(box_width))
                            : (MAG_W + 1)'(mag_reg);
    assign fold_next = folded[MAG_W] ? MAG_W'(-folded) : folded[MAG_W-1:0];

    // Stage 3: square
    assign product = fold_reg * fold_reg;

    always_ff @(posedge aclk) begin
        if (en.diff) begin
            mag_reg <= mag_next;
        end
        if (en.fold) begin
            fold_reg <= fold_next;
        end
        if (en.square) begin
            sq_reg <= product[SQ_W-1:0];
        end
    end

    assign axis_sq = sq_reg;

endmodule

// ===== rtl/ppcc_classify.sv =====
module ppcc_classify #(
    parameter int NUM_CUT = ppcc_pkg::CUT_REGS
) (
    input  logic                              aclk,
    input  ppcc_pkg::pipe_en_t                en,
    input  logic [ppcc_pkg::SQ_W-1:0]         sq_x,
    input  logic [ppcc_pkg::SQ_W-1:0]         sq_y,
    input  logic [ppcc_pkg::SQ_W-1:0]         sq_z,
    input  logic [NUM_CUT-1:0][ppcc_pkg::CUT_W-1:0] cutoff_sq,
    input  logic [ppcc_pkg::CLASS_W-1:0]      active_count,
    output logic [ppcc_pkg::CLASS_W-1:0]      shell_class
);
    import ppcc_pkg::*;

    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic [CLASS_W-1:0] class_reg, class_next;

    // Stage 4: squared distance
    assign dist_next = DIST_W'(sq_x) + DIST_W'(sq_y) + DIST_W'(sq_z);

    // Stage 5: first active shell whose cutoff lies above the distance
    always_comb begin
        class_next = '0;
        for (int i = NUM_CUT - 1; i >= 0; i--) begin
            if (i < int'(active_count) && dist_reg < DIST_W'(cutoff_sq[i])) begin
                class_next = CLASS_W'(i + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.sum) begin
            dist_reg <= dist_next;
        end
        if (en.result) begin
            class_reg <= class_next;
        end
    end

    assign shell_class = class_reg;

endmodule

// ===== rtl/periodic_pair_cutoff_classifier.sv =====
// Minimum-image pair classifier: each transaction carries a reference and a
// candidate position in signed Q12.12; the block folds each axis difference
// once by the box width, sums the squares into a Q24.24 squared distance and
// returns the first of the active shells whose squared cutoff lies above it
// (0 when none does). It is a five-stage pipeline (difference, fold, square,
// sum, compare) that takes one transaction per cycle while the output is not
// stalled; a result leaves once it has passed every stage register in order,
// and a stall on the output side holds each stage in place without losing data.
// Configuration is written through cfg_we/cfg_index/cfg_wdata and must only
// change while no transaction is in flight.
module periodic_pair_cutoff_classifier #(
    parameter int MAX_SHELLS = ppcc_pkg::MAX_SHELLS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [ppcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ppcc_pkg::CUT_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [ppcc_pkg::COORD_W-1:0] s_ref_x,
    input  logic signed [ppcc_pkg::COORD_W-1:0] s_ref_y,
    input  logic signed [ppcc_pkg::COORD_W-1:0] s_ref_z,
    input  logic signed [ppcc_pkg::COORD_W-1:0] s_cand_x,
    input  logic signed [ppcc_pkg::COORD_W-1:0] s_cand_y,
    input  logic signed [ppcc_pkg::COORD_W-1:0] s_cand_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ppcc_pkg::CLASS_W-1:0]        m_shell_class
);
    import ppcc_pkg::*;

    localparam int NUM_CUT = (MAX_SHELLS < CUT_REGS) ? MAX_SHELLS : CUT_REGS;
    localparam int STAGES  = 5;

    logic [BOX_W-1:0]              box_width_x, box_width_y, box_width_z;
    logic [NUM_CUT-1:0][CUT_W-1:0] cutoff_sq;
    logic [CLASS_W-1:0]            active_count;
    logic [STAGES-1:0]             valid_reg, valid_next;
    logic [STAGES-1:0]             stage_rdy;
    pipe_en_t                      en;
    logic [SQ_W-1:0]               sq_x, sq_y, sq_z;

    // Ready ripples back from the output: a stage loads when empty or draining
    always_comb begin
        stage_rdy[STAGES-1] = !valid_reg[STAGES-1] || m_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            stage_rdy[i] = !valid_reg[i] || stage_rdy[i+1];
        end
    end

    assign en = '{diff: stage_rdy[0], fold: stage_rdy[1], square: stage_rdy[2],
                  sum: stage_rdy[3], result: stage_rdy[4]};

    // Advance valid bits alongside the data
    always_comb begin
        for (int i = 0; i < STAGES; i++) begin
            if (stage_rdy[i]) begin
                valid_next[i] = (i == 0) ? s_valid : valid_reg[(i == 0) ? 0 : i - 1];
            end else begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    ppcc_cfg #(.NUM_CUT(NUM_CUT)) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .box_width_x  (box_width_x),
        .box_width_y  (box_width_y),
        .box_width_z  (box_width_z),
        .cutoff_sq    (cutoff_sq),
        .active_count (active_count)
    );

    ppcc_axis u_axis_x (
        .aclk      (aclk),
        .en        (en),
        .ref_pos   (s_ref_x),
        .cand_pos  (s_cand_x),
        .box_width (box_width_x),
        .axis_sq   (sq_x)
    );

    ppcc_axis u_axis_y (
        .aclk      (aclk),
        .en        (en),
        .ref_pos   (s_ref_y),
        .cand_pos  (s_cand_y),
        .box_width (box_width_y),
        .axis_sq   (sq_y)
    );

    ppcc_axis u_axis_z (
        .aclk      (aclk),
        .en        (en),
        .ref_pos   (s_ref_z),
        .cand_pos  (s_cand_z),
        .box_width (box_width_z),
        .axis_sq   (sq_z)
    );

    ppcc_classify #(.NUM_CUT(NUM_CUT)) u_classify (
        .aclk         (aclk),
        .en           (en),
        .sq_x         (sq_x),
        .sq_y         (sq_y),
        .sq_z         (sq_z),
        .cutoff_sq    (cutoff_sq),
        .active_count (active_count),
        .shell_class  (m_shell_class)
    );

    assign s_ready = stage_rdy[0];
    assign m_valid = valid_reg[STAGES-1];

endmodule

// ===== rtl/ppcc_checker.sv =====
module ppcc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [ppcc_pkg::CLASS_W-1:0] m_shell_class
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_shell_class))
        else $error("stalled result changed or dropped");

    // Come out of reset with nothing pending
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result pending right after reset");

    // With the output draining, each accepted transaction shows as a result once it has passed every stage register
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn, 1) && $past(aresetn, 2) && $past(aresetn, 3) &&
        $past(aresetn, 4) && $past(aresetn, 5) &&
        $past(m_ready, 1) && $past(m_ready, 2) && $past(m_ready, 3) && $past(m_ready, 4) &&
        $past(m_ready, 5)
        |-> m_valid == $past(s_valid && s_ready, 5))
        else $error("result lost, repeated or invented in a free-running pipeline");

endmodule

bind periodic_pair_cutoff_classifier ppcc_checker u_checker (.*);
